/* design/swks_pkg.sv */
// Package for the sliding-window rank-order filter.
// Holds state type, register indexes and default sizes; no dependencies.
package swks_pkg;
    localparam int WindowMaxDefault   = 64;
    localparam int SampleWidthDefault = 32;
    localparam int CfgIndexWidth      = 1;
    localparam int CfgDataWidth       = 7;
    localparam logic [CfgIndexWidth-1:0] CFG_WINDOW_LEN = 1'b0;
    localparam logic [CfgIndexWidth-1:0] CFG_RANK       = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SHIFT,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic load;    // capture sample, compute remove/insert
        logic commit;  // update cells, ring, pointers
        logic clear;   // restart window
    } cmd_t;

    typedef struct packed {
        logic full;    // window full after commit
    } stat_t;
endpackage

/* design/sliding_window_kth_smallest.sv */
// Sliding-window rank-order filter, top level.
// Holds configuration registers; instantiates swks_ctrl and swks_dp.
// Depends on swks_pkg.
//
// Samples arrive on s_valid/s_ready/s_sample; each transfer is stored in a
// window of the last window_len samples (1..WINDOW_MAX), kept sorted in a chain
// of compare-and-shift cells. Once the window is full, every sample gives one
// result on m_valid/m_ready/m_kth_value: the rank-th smallest window sample.
// While the window fills, samples give no result.
// Configuration: cfg_valid/cfg_ready/cfg_index/cfg_data; index 0 is window_len
// (writing it empties the window), index 1 is rank. Write only while idle.
// Sequence: each sample passes through the three controller states, ST_IDLE
// (capture), ST_SHIFT (one cell-chain update) and ST_OUT (result); a new sample
// is accepted only after the last one has left ST_OUT, so the block takes no
// new sample before it is through with the last one.
// A stalled receiver holds the result and s_ready stays low until transfer.
// Reset: window empty, window_len 8, rank 1.
module sliding_window_kth_smallest
    import swks_pkg::*;
#(
    parameter int WINDOW_MAX   = WindowMaxDefault,
    parameter int SAMPLE_WIDTH = SampleWidthDefault
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic signed [SAMPLE_WIDTH-1:0] s_sample,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic signed [SAMPLE_WIDTH-1:0] m_kth_value,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [CfgIndexWidth-1:0]       cfg_index,
    input  logic [CfgDataWidth-1:0]        cfg_data
);
    logic [CfgDataWidth-1:0] window_len_reg, rank_reg;
    logic  cfg_clear;
    cmd_t  cmd;
    stat_t stat;

    assign cfg_ready = 1'b1;
    assign cfg_clear = cfg_valid && (cfg_index == CFG_WINDOW_LEN);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_len_reg <= CfgDataWidth'(8);
            rank_reg       <= CfgDataWidth'(1);
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_WINDOW_LEN: window_len_reg <= cfg_data;
                CFG_RANK:       rank_reg       <= cfg_data;
                default: ;
            endcase
        end
    end

    swks_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .cfg_clear (cfg_clear),
        .cmd       (cmd),
        .stat      (stat)
    );

    swks_dp #(
        .WINDOW_MAX   (WINDOW_MAX),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .stat        (stat),
        .s_sample    (s_sample),
        .window_len  (window_len_reg),
        .rank        (rank_reg),
        .m_kth_value (m_kth_value)
    );
endmodule

/* design/swks_ctrl.sv */
// Controller for the rank-order filter: sequences load, commit and output.
// Depends on swks_pkg.
module swks_ctrl
    import swks_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  s_valid,
    output logic  s_ready,
    output logic  m_valid,
    input  logic  m_ready,
    input  logic  cfg_clear,
    output cmd_t  cmd,
    input  stat_t stat
);
    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        s_ready    = 1'b0;
        m_valid    = 1'b0;
        cmd        = '0;
        cmd.clear  = cfg_clear;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_SHIFT;
                end
            end
            ST_SHIFT: begin
                cmd.commit = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (!stat.full) begin
                    state_next = ST_IDLE;
                end else begin
                    m_valid = 1'b1;
                    if (m_ready) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end
endmodule

/* design/swks_dp.sv */
// Datapath of the rank-order filter: compare-and-shift cell chain, arrival ring,
// window pointers and result selection. Depends on swks_pkg.
module swks_dp
    import swks_pkg::*;
#(
    parameter int WINDOW_MAX   = WindowMaxDefault,
    parameter int SAMPLE_WIDTH = SampleWidthDefault
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  cmd_t                           cmd,
    output stat_t                          stat,
    input  logic signed [SAMPLE_WIDTH-1:0] s_sample,
    input  logic [CfgDataWidth-1:0]        window_len,
    input  logic [CfgDataWidth-1:0]        rank,
    output logic signed [SAMPLE_WIDTH-1:0] m_kth_value
);
    localparam int PW = $clog2(WINDOW_MAX);
    localparam int CW = $clog2(WINDOW_MAX + 1);
    localparam int LW = (CW > CfgDataWidth) ? CW : CfgDataWidth;

    logic [SAMPLE_WIDTH-1:0] cell_reg [WINDOW_MAX];
    logic [SAMPLE_WIDTH-1:0] ring_reg [WINDOW_MAX];
    logic [PW-1:0]           ptr_reg;
    logic [CW-1:0]           fill_reg;
    logic [SAMPLE_WIDTH-1:0] key_reg, old_reg;
    logic                    rm_reg;
    logic [CW-1:0]           win;
    logic [LW-1:0]           wl_ext, rk_ext;
    logic [CW-1:0]           rk;
    logic [WINDOW_MAX-1:0]   le_new, eq_old, valid_v, del_v, past_del;
    logic [SAMPLE_WIDTH-1:0] cell_next [WINDOW_MAX];
    logic [SAMPLE_WIDTH-1:0] key_now;
    logic [CW-1:0]           fill_after;

    assign key_now = s_sample ^ {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
    assign wl_ext  = LW'(window_len);
    assign rk_ext  = LW'(rank);

    always_comb begin
        if (wl_ext == '0) begin
            win = CW'(1);
        end else if (wl_ext > LW'(WINDOW_MAX)) begin
            win = CW'(WINDOW_MAX);
        end else begin
            win = CW'(wl_ext);
        end
        if (rk_ext == '0) begin
            rk = CW'(1);
        end else if (rk_ext > LW'(win)) begin
            rk = win;
        end else begin
            rk = CW'(rk_ext);
        end
    end

    // first matching copy of the departing key is dropped
    always_comb begin
        for (int i = 0; i < WINDOW_MAX; i++) begin
            valid_v[i] = (CW'(i) < fill_reg);
            eq_old[i]  = valid_v[i] && rm_reg && (cell_reg[i] == old_reg);
        end
        past_del[0] = 1'b0;
        for (int i = 1; i < WINDOW_MAX; i++) begin
            past_del[i] = past_del[i-1] | eq_old[i-1];
        end
        del_v = eq_old & ~past_del;
    end

    // compact view after removal, then insert after equal keys
    logic [SAMPLE_WIDTH-1:0] comp [WINDOW_MAX];
    logic [CW-1:0]           cnt_rm;
    always_comb begin
        cnt_rm = fill_reg - CW'(|eq_old);
        for (int i = 0; i < WINDOW_MAX; i++) begin
            if (past_del[i] || del_v[i]) begin
                comp[i] = (i + 1 < WINDOW_MAX) ? cell_reg[(i + 1) % WINDOW_MAX]
                                               : cell_reg[i];
            end else begin
                comp[i] = cell_reg[i];
            end
            le_new[i] = (CW'(i) < cnt_rm) && (comp[i] <= key_reg);
        end
        for (int i = 0; i < WINDOW_MAX; i++) begin
            if (le_new[i]) begin
                cell_next[i] = comp[i];
            end else if (i == 0 || le_new[(i + WINDOW_MAX - 1) % WINDOW_MAX]) begin
                cell_next[i] = key_reg;
            end else begin
                cell_next[i] = comp[(i + WINDOW_MAX - 1) % WINDOW_MAX];
            end
        end
        fill_after = (cnt_rm >= CW'(WINDOW_MAX)) ? cnt_rm : cnt_rm + CW'(1);
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            key_reg <= key_now;
            old_reg <= ring_reg[(CW'(ptr_reg) >= win) ? '0 : ptr_reg];
        end
        if (cmd.commit) begin
            for (int i = 0; i < WINDOW_MAX; i++) begin
                cell_reg[i] <= cell_next[i];
            end
            ring_reg[ptr_reg] <= key_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.clear) begin
            ptr_reg  <= '0;
            fill_reg <= '0;
            rm_reg   <= 1'b0;
        end else begin
            if (cmd.load) begin
                rm_reg <= (fill_reg >= win);
                if (CW'(ptr_reg) >= win) begin
                    ptr_reg <= '0;
                end
            end
            if (cmd.commit) begin
                fill_reg <= fill_after;
                ptr_reg  <= (CW'(ptr_reg) + CW'(1) >= win) ? '0 : ptr_reg + PW'(1);
            end
        end
    end

    assign stat.full   = (fill_reg >= win);
    assign m_kth_value = cell_reg[rk[PW-1:0] - PW'(1)] ^ {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
endmodule

/* tb/sv/tb_top.sv */
// Testbench for the sliding-window rank-order filter: drives samples and register
// writes, predicts each window's rank-th smallest value and checks every result.
// Depends on swks_pkg and sliding_window_kth_smallest.
module tb_top;
    import swks_pkg::*;

    localparam int WMAX = WindowMaxDefault;
    localparam int SW   = SampleWidthDefault;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic signed [SW-1:0] s_sample = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [SW-1:0] m_kth_value;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CfgIndexWidth-1:0] cfg_index = CFG_WINDOW_LEN;
    logic [CfgDataWidth-1:0] cfg_data = '0;

    sliding_window_kth_smallest DUT (.*);

    always #2 aclk = ~aclk;

    // predictor state
    logic signed [SW-1:0] win_sorted[WMAX];
    logic signed [SW-1:0] win_ring[WMAX];
    int ring_ptr = 0;
    int fill = 0;
    int cur_len = 8;
    int cur_rank = 1;

    logic signed [SW-1:0] pending_samples[$];
    logic signed [SW-1:0] expected_kth[$];
    int send_idle_pct = 33;
    int recv_idle_pct = 64;
    int hold_recv = 0;
    bit send_pause = 1'b0;
    int mismatches = 0;
    bit failed = 1'b0;

    // sample acceptance (s_valid && s_ready) as seen at the last rising edge
    logic s_ready_q = 1'b0;

    function automatic int clamp_len(int v);
        if (v == 0) return 1;
        if (v > WMAX) return WMAX;
        return v;
    endfunction

    task automatic queue_sample(logic signed [SW-1:0] x);
        pending_samples = {pending_samples, x};
    endtask

    task automatic predict_kth(logic signed [SW-1:0] x);
        int w;
        int i;
        int pos;
        int r;
        w = clamp_len(cur_len);
        if (ring_ptr >= w) ring_ptr = 0;
        if (fill >= w) begin
            i = 0;
            while (i < fill && win_sorted[i] != win_ring[ring_ptr]) i++;
            if (i < fill) begin
                for (; i + 1 < fill; i++) win_sorted[i] = win_sorted[i+1];
                fill--;
            end
        end
        if (fill < WMAX) begin
            pos = 0;
            while (pos < fill && win_sorted[pos] <= x) pos++;
            for (i = fill; i > pos; i--) win_sorted[i] = win_sorted[i-1];
            win_sorted[pos] = x;
            fill++;
        end
        win_ring[ring_ptr] = x;
        ring_ptr++;
        if (ring_ptr >= w) ring_ptr = 0;
        if (fill >= w) begin
            r = cur_rank;
            if (r == 0) r = 1;
            if (r > w) r = w;
            expected_kth = {expected_kth, win_sorted[r-1]};
        end
    endtask

    // driver
    always @(negedge aclk) begin
        if (aresetn) begin
            if (!s_valid || s_ready_q) begin
                if (pending_samples.size() > 0 && !send_pause &&
                        $urandom_range(99) >= send_idle_pct) begin
                    s_valid <= 1'b1;
                    s_sample <= pending_samples[0];
                    pending_samples.delete(0);
                end else begin
                    s_valid <= 1'b0;
                end
            end
            m_ready <= (hold_recv == 0) && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // receiver hold-off countdown
    always @(posedge aclk) begin
        if (hold_recv > 0) hold_recv <= hold_recv - 1;
    end

    // monitor
    always @(posedge aclk) begin
        s_ready_q <= s_valid && s_ready;
        if (aresetn && s_valid && s_ready) predict_kth(s_sample);
        if (aresetn && m_valid && m_ready) begin
            if (expected_kth.size() == 0) begin
                failed = 1'b1;
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %0d", m_kth_value);
            end else begin
                if (m_kth_value !== expected_kth[0]) begin
                    failed = 1'b1;
                    mismatches++;
                    if (mismatches <= 10)
                        $display("kth_value mismatch: expected %0d actual %0d",
                                 expected_kth[0], m_kth_value);
                end
                expected_kth.delete(0);
            end
        end
    end

    task automatic drain();
        while (pending_samples.size() > 0 || s_valid || expected_kth.size() > 0)
            @(posedge aclk);
        repeat (10) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CfgIndexWidth-1:0] idx, int v);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v[CfgDataWidth-1:0];
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        if (idx == CFG_WINDOW_LEN) begin
            cur_len = v & 8'h7f;
            fill = 0;
            ring_ptr = 0;
        end else begin
            cur_rank = v & 8'h7f;
        end
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic signed [SW-1:0] rand_sample();
        case ($urandom_range(3))
            0: return $urandom_range(7) - 4;
            1: return {$urandom_range(1) ? 1'b1 : 1'b0, {(SW-1){$urandom_range(1) ? 1'b1 : 1'b0}}};
            default: return $urandom();
        endcase
    endfunction

    task automatic run_phase(int len, int rk, int n);
        write_reg(CFG_WINDOW_LEN, len);
        write_reg(CFG_RANK, rk);
        for (int i = 0; i < n; i++) queue_sample(rand_sample());
        drain();
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        // directed: reset settings, extremes and duplicates
        queue_sample(32'sh7fffffff);
        queue_sample(32'sh80000000);
        queue_sample(0);
        queue_sample(-1);
        queue_sample(5);
        queue_sample(5);
        queue_sample(5);
        queue_sample(32'sh80000000);
        queue_sample(32'sh7fffffff);
        queue_sample(1);
        drain();
        run_phase(1, 0, 6);
        run_phase(0, 1, 4);
        run_phase(3, 100, 8);
        run_phase(100, 64, 70);
        // random, with idling patterns
        for (int p = 0; p < 3; p++) begin
            if (p == 1) begin
                send_idle_pct = 64;
                recv_idle_pct = 33;
            end else if (p == 2) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            run_phase(1 + $urandom_range(15), $urandom_range(20), 120);
            run_phase(64, $urandom_range(1, 64), 100);
            run_phase($urandom_range(1, 8), $urandom_range(1, 8), 100);
        end
        // long receiver hold-off while sender keeps offering
        write_reg(CFG_WINDOW_LEN, 4);
        write_reg(CFG_RANK, 2);
        hold_recv = 300;
        for (int i = 0; i < 60; i++) queue_sample(rand_sample());
        drain();
        if (!failed && expected_kth.size() == 0) begin
            $display("sliding_window_kth_smallest test passed");
        end else begin
            $display("sliding_window_kth_smallest test failed");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("sliding_window_kth_smallest test failed");
        $finish;
    end
endmodule
